FILE: hw/rtl/tts_pkg.sv
// ---------------------------------------------------------------------------
// tts_pkg: shared types and constants of the tick task scheduler table
// Holds the table geometry, operation, status and error codes, the command
// and result words, and the token that walks the row of slot cells.
// ---------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	// Table geometry
	localparam int NUM_SLOTS = 8;
	localparam int TIME_BITS = 16;
	localparam int MAX_RES   = 8;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_RES + 1);

	// Operation codes
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_ADD       = 3'd1;
	localparam logic [2:0] OP_DELETE    = 3'd2;
	localparam logic [2:0] OP_DISP_ALL  = 3'd3;
	localparam logic [2:0] OP_DISP_SLOT = 3'd4;
	localparam logic [2:0] OP_REFRESH   = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Sticky error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_TOO_MANY  = 2'd1;
	localparam logic [1:0] ERR_NO_DELETE = 2'd2;

	typedef logic [TIME_BITS-1:0] tick_t;
	typedef logic [SLOT_W-1:0]    pos_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// Command word
	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  slot;
		logic [7:0]  task_id;
		logic [15:0] start_delay;
		logic [15:0] run_period;
	} cmd_t;

	// Result word
	typedef struct packed {
		logic [2:0] result_slot;
		logic [7:0] result_task;
		logic [1:0] status;
		logic       ready_res;
		logic [1:0] error_state;
		logic       last;
	} res_t;

	// Contents of one slot
	typedef struct packed {
		logic       used;
		logic [7:0] task_id;
		tick_t      delay;
		tick_t      period;
		logic [7:0] pending;
	} slot_t;

	// Command token handed from cell to cell
	typedef struct packed {
		logic       valid;
		logic [2:0] op;
		logic [2:0] slot;
		logic [7:0] task_id;
		tick_t      delay;
		tick_t      period;
		pos_t       pos;
		logic       found;
		logic [2:0] res_slot;
		logic [7:0] res_task;
		cnt_t       cnt;
	} tok_t;

	// Dispatch report from one cell
	typedef struct packed {
		logic       valid;
		logic [2:0] slot;
		logic [7:0] task_id;
	} emit_t;

	// Time value kept in TIME_BITS bits
	function automatic tick_t to_tick(input logic [15:0] v);
		return TIME_BITS'(v);
	endfunction

	// Low three bits of a cell position
	function automatic logic [2:0] to_slot3(input pos_t p);
		return 3'(p);
	endfunction

	// True when the addressed slot is this cell; out-of-range never matches
	function automatic logic slot_match(input logic [2:0] s, input pos_t p);
		return int'(s) == int'(p);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tts_cell.sv
// ---------------------------------------------------------------------------
// tts_cell: one slot of the scheduler table
// Holds one slot, applies the passing command token to it, hands the token
// on to the next cell and reports a dispatch hit for dispatch-all.
// ---------------------------------------------------------------------------
`default_nettype none

module tts_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tts_pkg::tok_t  tok_in,
	output tts_pkg::tok_t       tok_out,
	output tts_pkg::emit_t      emit
);

	tts_pkg::slot_t st_q, st_d;
	tts_pkg::tok_t  tok_q, tok_d;
	tts_pkg::emit_t emit_q, emit_d;
	logic           match;
	logic           ready;

	assign match = tts_pkg::slot_match(tok_in.slot, tok_in.pos);
	assign ready = st_q.used && (st_q.pending != 8'd0);

	// Apply the token to this slot
	always_comb begin
		st_d        = st_q;
		tok_d       = tok_in;
		tok_d.pos   = tts_pkg::pos_t'(tok_in.pos + 1'b1);
		emit_d      = '0;
		if (tok_in.valid) begin
			unique case (tok_in.op)
				tts_pkg::OP_TICK: begin
					if (st_q.used) begin
						if (st_q.delay == '0) begin
							if (st_q.pending != 8'hFF) st_d.pending = st_q.pending + 8'd1;
							if (st_q.period != '0) st_d.delay = st_q.period;
						end else begin
							st_d.delay = st_q.delay - 1'b1;
						end
					end
				end
				tts_pkg::OP_ADD: begin
					if (!tok_in.found && !st_q.used) begin
						st_d.used      = 1'b1;
						st_d.task_id   = tok_in.task_id;
						st_d.delay     = tok_in.delay;
						st_d.period    = tok_in.period;
						st_d.pending   = 8'd0;
						tok_d.found    = 1'b1;
						tok_d.res_slot = tts_pkg::to_slot3(tok_in.pos);
					end
				end
				tts_pkg::OP_DELETE: begin
					if (match) begin
						tok_d.found  = st_q.used;
						st_d.used    = 1'b0;
						st_d.pending = 8'd0;
					end
				end
				tts_pkg::OP_DISP_ALL: begin
					if (ready && (int'(tok_in.cnt) < tts_pkg::MAX_RES)) begin
						emit_d.valid   = 1'b1;
						emit_d.slot    = tts_pkg::to_slot3(tok_in.pos);
						emit_d.task_id = st_q.task_id;
						tok_d.cnt      = tts_pkg::cnt_t'(tok_in.cnt + 1'b1);
						st_d.pending   = st_q.pending - 8'd1;
						if (st_q.period == '0) st_d.used = 1'b0;
					end
				end
				tts_pkg::OP_DISP_SLOT: begin
					if (match && ready) begin
						tok_d.found    = 1'b1;
						tok_d.res_task = st_q.task_id;
						st_d.pending   = st_q.pending - 8'd1;
						if (st_q.period == '0) st_d.used = 1'b0;
					end
				end
				tts_pkg::OP_REFRESH: begin
					if (match && st_q.used) begin
						st_d.delay   = st_q.period;
						st_d.pending = 8'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold slot state, pass the token on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			tok_q  <= '0;
			emit_q <= '0;
		end else begin
			st_q   <= st_d;
			tok_q  <= tok_d;
			emit_q <= emit_d;
		end
	end

	assign tok_out = tok_q;
	assign emit    = emit_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tts_chain.sv
// ---------------------------------------------------------------------------
// tts_chain: row of slot cells
// Links the cells in index order and merges their dispatch reports; only
// one token walks the row, so at most one cell reports in any cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tts_chain (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tts_pkg::tok_t  tok_in,
	output tts_pkg::tok_t       tok_out,
	output tts_pkg::emit_t      emit
);

	tts_pkg::tok_t  tok_w  [tts_pkg::NUM_SLOTS+1];
	tts_pkg::emit_t emit_w [tts_pkg::NUM_SLOTS];

	assign tok_w[0] = tok_in;

	// Build the row
	for (genvar g = 0; g < tts_pkg::NUM_SLOTS; g++) begin : g_cell
		tts_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_w[g]),
			.tok_out (tok_w[g+1]),
			.emit    (emit_w[g])
		);
	end

	// Merge reports; idle cells drive zero
	always_comb begin
		emit = '0;
		for (int i = 0; i < tts_pkg::NUM_SLOTS; i++) begin
			emit = emit | emit_w[i];
		end
	end

	assign tok_out = tok_w[tts_pkg::NUM_SLOTS];

endmodule

`default_nettype wire

FILE: hw/rtl/tick_task_scheduler_table_unit.sv
// ---------------------------------------------------------------------------
// tick_task_scheduler_table_unit: tick-driven task scheduler table
// Command port, slot cell row, result assembly and sticky error register.
// ---------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. The command
// walks the row of slot cells one cell per cycle; busy stays high until the
// final result is shown and drops with it, so the next command may be taken
// at the end of that cycle. Each result word is shown for one cycle with
// res_valid high and cannot be held off. Tick, add, delete, dispatch-slot
// and refresh give one result; dispatch-all gives one per ready slot in
// index order (at most eight), or a single not-ready result. The word with
// last set ends each command. The table is empty after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module tick_task_scheduler_table_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire tts_pkg::cmd_t  cmd,
	output logic                res_valid,
	output tts_pkg::res_t       res
);

	tts_pkg::tok_t  tok_s0;
	tts_pkg::tok_t  chain_out;
	tts_pkg::tok_t  fin_q;
	tts_pkg::emit_t emit;
	tts_pkg::emit_t hold_q;
	tts_pkg::res_t  res_q;
	tts_pkg::res_t  fin_res;
	logic [1:0]     sticky_q;
	logic [1:0]     sticky_d;
	logic           busy_q;
	logic           res_valid_q;
	logic           accept;

	assign accept = start && !busy_q;

	tts_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_in  (tok_s0),
		.tok_out (chain_out),
		.emit    (emit)
	);

	// Build the final word of a command
	always_comb begin
		fin_res             = '0;
		fin_res.last        = 1'b1;
		fin_res.status      = tts_pkg::ST_OK;
		sticky_d            = sticky_q;
		unique case (fin_q.op)
			tts_pkg::OP_ADD: begin
				if (fin_q.found) begin
					fin_res.result_slot = fin_q.res_slot;
					fin_res.result_task = fin_q.task_id;
				end else begin
					fin_res.status = tts_pkg::ST_FULL;
					sticky_d       = tts_pkg::ERR_TOO_MANY;
				end
			end
			tts_pkg::OP_DELETE: begin
				fin_res.result_slot = fin_q.slot;
				if (!fin_q.found) begin
					fin_res.status = tts_pkg::ST_EMPTY;
					sticky_d       = tts_pkg::ERR_NO_DELETE;
				end
			end
			tts_pkg::OP_DISP_ALL: begin
				if (hold_q.valid) begin
					fin_res.result_slot = hold_q.slot;
					fin_res.result_task = hold_q.task_id;
					fin_res.ready_res   = 1'b1;
				end
			end
			tts_pkg::OP_DISP_SLOT: begin
				fin_res.result_slot = fin_q.slot;
				if (fin_q.found) begin
					fin_res.result_task = fin_q.res_task;
					fin_res.ready_res   = 1'b1;
				end
			end
			tts_pkg::OP_REFRESH: begin
				fin_res.result_slot = fin_q.slot;
			end
			default: begin
			end
		endcase
		fin_res.error_state = sticky_d;
	end

	// Control and payload: launch, hold one report back, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			tok_s0      <= '0;
			fin_q       <= '0;
			hold_q      <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			sticky_q    <= tts_pkg::ERR_NONE;
		end else begin
			tok_s0.valid <= accept;
			if (accept) begin
				tok_s0.op       <= cmd.op;
				tok_s0.slot     <= cmd.slot;
				tok_s0.task_id  <= cmd.task_id;
				tok_s0.delay    <= tts_pkg::to_tick(cmd.start_delay);
				tok_s0.period   <= tts_pkg::to_tick(cmd.run_period);
				tok_s0.pos      <= '0;
				tok_s0.found    <= 1'b0;
				tok_s0.res_slot <= 3'd0;
				tok_s0.res_task <= 8'd0;
				tok_s0.cnt      <= '0;
			end
			fin_q <= chain_out;
			if (fin_q.valid) begin
				busy_q       <= 1'b0;
				res_valid_q  <= 1'b1;
				sticky_q     <= sticky_d;
				hold_q.valid <= 1'b0;
				res_q        <= fin_res;
			end else begin
				if (accept) busy_q <= 1'b1;
				if (emit.valid) begin
					// release the report held back; a newer one follows
					res_valid_q       <= hold_q.valid;
					hold_q            <= emit;
					res_q.result_slot <= hold_q.slot;
					res_q.result_task <= hold_q.task_id;
					res_q.status      <= tts_pkg::ST_OK;
					res_q.ready_res   <= 1'b1;
					res_q.error_state <= sticky_q;
					res_q.last        <= 1'b0;
				end else begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	assign busy      = busy_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tts_checker.sv
// ---------------------------------------------------------------------------
// tts_checker: port-level checks of the scheduler table
// Watches the command and result ports for framing of result words.
// ---------------------------------------------------------------------------
`default_nettype none

module tts_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire tts_pkg::cmd_t cmd,
	input wire logic          res_valid,
	input wire tts_pkg::res_t res
);

	// A taken command keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after command word");

	// The final word ends the command
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> !busy)
		else $error("final word shown while still busy");

	// Only dispatch reports come before the final word
	a_mid_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> busy && res.ready_res
			&& (res.status == tts_pkg::ST_OK))
		else $error("non-final word is not a dispatch report");

	// Busy drops only with a final word
	a_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> res_valid && res.last)
		else $error("busy dropped without a final word");

endmodule

bind tick_task_scheduler_table_unit tts_checker u_tts_checker (.*);

`default_nettype wire

FILE: verif/tick_task_scheduler_table_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tick_task_scheduler_table_unit_tb: self-checking bench for the task table
// Drives command words through the start/busy port and keeps its own copy of
// the slot table to predict every result word. Each result word seen on the
// strobe is checked field by field against the oldest prediction. A directed
// pass covers the empty, full and one-shot cases, a run of ticks piles up
// pending runs on one slot, and a weighted random stream follows.
// ---------------------------------------------------------------------------

module tick_task_scheduler_table_unit_tb;

	localparam int RANDOM_WORDS = 122;
	localparam int PILE_TICKS = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = tts_pkg::NUM_SLOTS + 3 + 10;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	// Shadow of the slot table plus the queue of result words still due
	class task_table_scoreboard;
		logic            occ[tts_pkg::NUM_SLOTS];
		logic [7:0]      tid_of[tts_pkg::NUM_SLOTS];
		tts_pkg::tick_t  dly[tts_pkg::NUM_SLOTS];
		tts_pkg::tick_t  per[tts_pkg::NUM_SLOTS];
		logic [7:0]      runs[tts_pkg::NUM_SLOTS];
		logic [1:0]      sticky;
		tts_pkg::res_t   due_words[$];
		int              fails;

		function new();
			for (int i = 0; i < tts_pkg::NUM_SLOTS; i++)
				clear_entry(i);
			sticky = tts_pkg::ERR_NONE;
			fails = 0;
		endfunction

		function void clear_entry(int i);
			occ[i] = 1'b0;
			tid_of[i] = '0;
			dly[i] = '0;
			per[i] = '0;
			runs[i] = '0;
		endfunction

		function void push_word(logic [2:0] s, logic [7:0] tsk, logic [1:0] st, logic rdy);
			tts_pkg::res_t w;
			w.result_slot = s;
			w.result_task = tsk;
			w.status = st;
			w.ready_res = rdy;
			w.error_state = sticky;
			w.last = 1'b0;
			due_words.push_back(w);
		endfunction

		// Take one pending run; free the slot if it is one-shot
		function logic [7:0] take_run(int i);
			logic [7:0] tsk;
			tsk = tid_of[i];
			runs[i] = runs[i] - 8'd1;
			if (per[i] == '0)
				clear_entry(i);
			return tsk;
		endfunction

		// Update the shadow table and queue the words this command causes
		function void note_command(tts_pkg::cmd_t c);
			int n;
			int free_idx;
			int s;
			tts_pkg::res_t w;
			n = 0;
			s = int'(c.slot);
			case (c.op)
				tts_pkg::OP_TICK: begin
					for (int i = 0; i < tts_pkg::NUM_SLOTS; i++) begin
						if (occ[i]) begin
							if (dly[i] == '0) begin
								if (runs[i] != 8'hFF)
									runs[i] = runs[i] + 8'd1;
								if (per[i] != '0)
									dly[i] = per[i];
							end else begin
								dly[i] = dly[i] - 1'b1;
							end
						end
					end
					push_word(3'd0, 8'd0, tts_pkg::ST_OK, 1'b0);
				end
				tts_pkg::OP_ADD: begin
					free_idx = tts_pkg::NUM_SLOTS;
					for (int i = tts_pkg::NUM_SLOTS - 1; i >= 0; i--)
						if (!occ[i])
							free_idx = i;
					if (free_idx == tts_pkg::NUM_SLOTS) begin
						sticky = tts_pkg::ERR_TOO_MANY;
						push_word(3'd0, 8'd0, tts_pkg::ST_FULL, 1'b0);
					end else begin
						occ[free_idx] = 1'b1;
						tid_of[free_idx] = c.task_id;
						dly[free_idx] = tts_pkg::tick_t'(c.start_delay);
						per[free_idx] = tts_pkg::tick_t'(c.run_period);
						runs[free_idx] = '0;
						push_word(3'(free_idx), c.task_id, tts_pkg::ST_OK, 1'b0);
					end
				end
				tts_pkg::OP_DELETE: begin
					if (s < tts_pkg::NUM_SLOTS && occ[s]) begin
						clear_entry(s);
						push_word(c.slot, 8'd0, tts_pkg::ST_OK, 1'b0);
					end else begin
						if (s < tts_pkg::NUM_SLOTS)
							clear_entry(s);
						sticky = tts_pkg::ERR_NO_DELETE;
						push_word(c.slot, 8'd0, tts_pkg::ST_EMPTY, 1'b0);
					end
				end
				tts_pkg::OP_DISP_ALL: begin
					for (int i = 0; i < tts_pkg::NUM_SLOTS && n < tts_pkg::MAX_RES; i++) begin
						if (occ[i] && runs[i] != '0) begin
							push_word(3'(i), take_run(i), tts_pkg::ST_OK, 1'b1);
							n++;
						end
					end
					if (n == 0)
						push_word(3'd0, 8'd0, tts_pkg::ST_OK, 1'b0);
				end
				tts_pkg::OP_DISP_SLOT: begin
					if (s < tts_pkg::NUM_SLOTS && occ[s] && runs[s] != '0)
						push_word(c.slot, take_run(s), tts_pkg::ST_OK, 1'b1);
					else
						push_word(c.slot, 8'd0, tts_pkg::ST_OK, 1'b0);
				end
				tts_pkg::OP_REFRESH: begin
					if (s < tts_pkg::NUM_SLOTS && occ[s]) begin
						dly[s] = per[s];
						runs[s] = '0;
					end
					push_word(c.slot, 8'd0, tts_pkg::ST_OK, 1'b0);
				end
				default: begin
					push_word(3'd0, 8'd0, tts_pkg::ST_OK, 1'b0);
				end
			endcase
			// mark the final word of this command
			w = due_words.pop_back();
			w.last = 1'b1;
			due_words.push_back(w);
		endfunction

		function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
				fails++;
			end
		endfunction

		// Check one result word against the oldest prediction
		function void check_result(tts_pkg::res_t got);
			tts_pkg::res_t exp_w;
			if (due_words.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %p", $time, got);
				fails++;
			end else begin
				exp_w = due_words.pop_front();
				compare_field("result_slot", 8'(exp_w.result_slot), 8'(got.result_slot));
				compare_field("result_task", exp_w.result_task, got.result_task);
				compare_field("status", 8'(exp_w.status), 8'(got.status));
				compare_field("ready_res", 8'(exp_w.ready_res), 8'(got.ready_res));
				compare_field("error_state", 8'(exp_w.error_state), 8'(got.error_state));
				compare_field("last", 8'(exp_w.last), 8'(got.last));
			end
		endfunction

		function int outstanding();
			return due_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	tts_pkg::cmd_t cmd = '0;
	logic busy;
	logic res_valid;
	tts_pkg::res_t res;

	task_table_scoreboard sb;

	always #5 clk = ~clk;

	tick_task_scheduler_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.res_valid(res_valid),
		.res(res)
	);

	// Note accepted command words and check result words
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_command(cmd);
			if (res_valid)
				sb.check_result(res);
		end
	end

	// End the run if nothing moves for too long
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || res_valid)
				stalled = 0;
			else
				stalled++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	function automatic tts_pkg::cmd_t make_word(logic [2:0] op, logic [2:0] s, logic [7:0] tid,
			logic [15:0] d, logic [15:0] p);
		tts_pkg::cmd_t c;
		c.op = op;
		c.slot = s;
		c.task_id = tid;
		c.start_delay = d;
		c.run_period = p;
		return c;
	endfunction

	// Mostly short times so that runs come due, now and then the extremes
	function automatic logic [15:0] draw_time();
		int r;
		r = $urandom_range(0, 19);
		if (r < 6)
			return 16'd0;
		else if (r < 16)
			return 16'($urandom_range(1, 4));
		else if (r == 16)
			return 16'hFFFF;
		else
			return 16'($urandom_range(0, 65535));
	endfunction

	function automatic tts_pkg::cmd_t random_word();
		tts_pkg::cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		c.slot = 3'($urandom_range(0, 7));
		c.task_id = 8'($urandom);
		c.start_delay = draw_time();
		c.run_period = draw_time();
		if (pick < 35)
			c.op = tts_pkg::OP_TICK;
		else if (pick < 55)
			c.op = tts_pkg::OP_ADD;
		else if (pick < 65)
			c.op = tts_pkg::OP_DELETE;
		else if (pick < 80)
			c.op = tts_pkg::OP_DISP_ALL;
		else if (pick < 90)
			c.op = tts_pkg::OP_DISP_SLOT;
		else if (pick < 97)
			c.op = tts_pkg::OP_REFRESH;
		else if (pick < 99)
			c.op = OP_SPARE_A;
		else
			c.op = OP_SPARE_B;
		return c;
	endfunction

	// Present one command word after a gap and hold it until taken
	task automatic send_word(tts_pkg::cmd_t c, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every predicted word has arrived, then let the block settle
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (tts_pkg::NUM_SLOTS + 3) @(posedge clk);
	endtask

	function automatic int draw_gap();
		return $urandom_range(0, 6);
	endfunction

	initial begin : stimulus
		int gap;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table: nothing ready, empty delete, empty refresh, spare codes
		send_word(make_word(tts_pkg::OP_DISP_ALL, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_DISP_SLOT, 3'd5, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_REFRESH, 3'd2, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_DELETE, 3'd3, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(OP_SPARE_A, 3'd7, 8'hFF, 16'hFFFF, 16'hFFFF), draw_gap());
		send_word(make_word(OP_SPARE_B, 3'd1, 8'h5A, 16'h1234, 16'h8001), draw_gap());

		// one-shot due now, extreme periodic, short periodic
		send_word(make_word(tts_pkg::OP_ADD, 3'd0, 8'hFF, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_ADD, 3'd7, 8'h00, 16'hFFFF, 16'hFFFF), draw_gap());
		send_word(make_word(tts_pkg::OP_ADD, 3'd0, 8'hA5, 16'd1, 16'd2), draw_gap());
		send_word(make_word(tts_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_DISP_ALL, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_ADD, 3'd0, 8'h5A, 16'd0, 16'd1), draw_gap());
		send_word(make_word(tts_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_DISP_SLOT, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_REFRESH, 3'd2, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_DELETE, 3'd1, 8'd0, 16'd0, 16'd0), draw_gap());

		// fill the table, then overflow it
		for (int k = 0; k < 6; k++)
			send_word(make_word(tts_pkg::OP_ADD, 3'(k), 8'(8'h10 + k), 16'(k), 16'(5 - k)),
				draw_gap());
		send_word(make_word(tts_pkg::OP_ADD, 3'd0, 8'h77, 16'd3, 16'd3), draw_gap());
		send_word(make_word(tts_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_DISP_ALL, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		drain_results();

		// pile up pending runs on a due one-shot slot, then dispatch it
		send_word(make_word(tts_pkg::OP_DELETE, 3'd6, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_ADD, 3'd0, 8'h3C, 16'd0, 16'd0), draw_gap());
		for (int k = 0; k < PILE_TICKS; k++) begin
			gap = (k < PILE_TICKS / 2) ? 0 : draw_gap();
			send_word(make_word(tts_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0), gap);
		end
		send_word(make_word(tts_pkg::OP_DISP_ALL, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		send_word(make_word(tts_pkg::OP_DISP_ALL, 3'd0, 8'd0, 16'd0, 16'd0), draw_gap());
		drain_results();

		// weighted random stream with back-to-back bursts and full pauses
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k % 40 == 39)
				drain_results();
			gap = ((k / 16) % 3 == 1) ? 0 : draw_gap();
			send_word(random_word(), gap);
		end

		// wait out every predicted word, then let the block settle
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.outstanding() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
